FILE: rtl/itd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itd_pkg
// Shared constants and types of the integer to decimal text converter.
// ---------------------------------------------------------------------------
package itd_pkg;

    // width of the signed input value
    localparam int DATA_WIDTH = 32;

    // decimal digits needed for the largest magnitude, 2^(DATA_WIDTH-1)
    localparam int NUM_DIGITS = (DATA_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(DATA_WIDTH);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [3:0] RADIX      = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/itd_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itd_if
// Valid/ready channels of the converter: input value and output characters.
// ---------------------------------------------------------------------------
interface itd_in_if
    import itd_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface
`default_nettype wire

FILE: rtl/integer_to_decimal_text.sv
`default_nettype none
// ---------------------------------------------------------------------------
// integer_to_decimal_text
// Converts a signed integer to its decimal ASCII text, one character per
// output transfer.
// ---------------------------------------------------------------------------
// A value is taken when the block is idle. Its magnitude is converted to BCD
// by a shift-and-add-3 register, one input bit per cycle. The BCD register is
// then shifted out one digit per cycle over all NUM_DIGITS positions (10), a
// digit to be sent waiting while the output register holds an untaken
// character: leading zeros are dropped, every other digit becomes one
// character, with a leading '-' for a negative value. The most negative
// value is converted exactly. last_char marks the final character. An output
// register holds the pending character, so the next digit is prepared while
// the previous transfer waits.
// ---------------------------------------------------------------------------
module integer_to_decimal_text
    import itd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    itd_in_if.sink       i_value_ch,
    itd_out_if.source    o_text_ch
);

    typedef struct packed {
        logic load;
        logic step;
        logic shift_digit;
        logic push;
        logic push_sign;
    } t_ctrl;

    t_state                 r_state, n_state;
    logic [DATA_WIDTH-1:0]  r_mag, n_mag;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [BCD_W-1:0]       w_bcd_adj;
    logic                   r_neg, n_neg;
    logic [BIT_CNT_W-1:0]   r_bit_cnt, n_bit_cnt;
    logic [DIG_CNT_W-1:0]   r_dig_left, n_dig_left;
    logic                   r_started, n_started;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_char, n_out_char;
    logic                   r_out_last, n_out_last;

    logic                   w_accept;
    logic                   w_slot_free;
    logic [3:0]             w_top;
    logic                   w_skip_zero;
    logic                   w_last_digit;
    t_ctrl                  w_ctrl;

    assign w_accept     = i_value_ch.valid && i_value_ch.ready;
    assign w_slot_free  = !r_out_valid || o_text_ch.ready;
    assign w_top        = r_bcd[BCD_W-1 -: 4];
    assign w_last_digit = (r_dig_left == DIG_CNT_W'(1));
    assign w_skip_zero  = !r_started && (w_top == 4'd0) && !w_last_digit;

    assign i_value_ch.ready    = (r_state == ST_IDLE);
    assign o_text_ch.valid     = r_out_valid;
    assign o_text_ch.text_char = r_out_char;
    assign o_text_ch.last_char = r_out_last;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            w_bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ?
                                  r_bcd[4*d +: 4] + 4'd3 : r_bcd[4*d +: 4];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_bit_cnt == '0) begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (w_slot_free) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!w_skip_zero && w_slot_free && w_last_digit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_ctrl = '0;
        case (r_state)
            ST_IDLE: w_ctrl.load = w_accept;
            ST_CONV: w_ctrl.step = 1'b1;
            ST_SIGN: begin
                w_ctrl.push      = w_slot_free;
                w_ctrl.push_sign = w_slot_free;
            end
            ST_EMIT: begin
                w_ctrl.shift_digit = w_skip_zero || w_slot_free;
                w_ctrl.push        = !w_skip_zero && w_slot_free;
            end
            default: w_ctrl = '0;
        endcase
    end

    // datapath
    always_comb begin
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_bit_cnt   = r_bit_cnt;
        n_dig_left  = r_dig_left;
        n_started   = r_started;
        n_out_valid = r_out_valid && !o_text_ch.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        if (w_ctrl.load) begin
            n_neg      = i_value_ch.value[DATA_WIDTH-1];
            n_mag      = i_value_ch.value[DATA_WIDTH-1] ?
                         DATA_WIDTH'(~i_value_ch.value) + DATA_WIDTH'(1) :
                         DATA_WIDTH'(i_value_ch.value);
            n_bcd      = '0;
            n_bit_cnt  = BIT_CNT_W'(DATA_WIDTH - 1);
            n_dig_left = DIG_CNT_W'(NUM_DIGITS);
            n_started  = 1'b0;
        end
        if (w_ctrl.step) begin
            n_bcd     = {w_bcd_adj[BCD_W-2:0], r_mag[DATA_WIDTH-1]};
            n_mag     = {r_mag[DATA_WIDTH-2:0], 1'b0};
            n_bit_cnt = r_bit_cnt - BIT_CNT_W'(1);
        end
        if (w_ctrl.shift_digit) begin
            n_bcd      = {r_bcd[BCD_W-5:0], 4'd0};
            n_dig_left = r_dig_left - DIG_CNT_W'(1);
        end
        if (w_ctrl.push) begin
            n_out_valid = 1'b1;
            if (w_ctrl.push_sign) begin
                n_out_char = CHAR_MINUS;
                n_out_last = 1'b0;
            end else begin
                n_out_char = CHAR_ZERO + {4'd0, w_top};
                n_out_last = w_last_digit;
                n_started  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
            r_bit_cnt   <= '0;
            r_dig_left  <= '0;
            r_neg       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_started   <= n_started;
            r_bit_cnt   <= n_bit_cnt;
            r_dig_left  <= n_dig_left;
            r_neg       <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_bcd      <= n_bcd;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // a transfer in always starts conversion
    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_CONV))
        else $error("accepted value did not start conversion");

    // digits are shifted out only while some remain
    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_dig_left != '0))
        else $error("emit state with no digits left");

    // bcd digits stay decimal while shifting out
    a_top_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (w_top < RADIX))
        else $error("non-decimal digit in bcd register");

    // only a sign or a digit character is ever presented
    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_char == CHAR_MINUS) ||
                         ((r_out_char >= CHAR_ZERO) &&
                          (r_out_char < CHAR_ZERO + {4'd0, RADIX}))))
        else $error("illegal output character");

    // a sign is never the final character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_char == CHAR_MINUS)) |-> !r_out_last)
        else $error("sign flagged as last character");

endmodule
`default_nettype wire

FILE: tb/itd_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itd_checker
// Watches both channels of the converter. Every accepted value is turned
// into its expected decimal text, and every character transfer is compared
// with the oldest character still owed.
// ---------------------------------------------------------------------------
module itd_checker
    import itd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    itd_in_if    i_value_ch,
    itd_out_if   i_text_ch,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } t_text_beat;

    t_text_beat text_owed[$];

    // decimal text of one value, sign first, no leading zeros
    function automatic void owe_text_of(logic signed [DATA_WIDTH-1:0] value);
        logic [DATA_WIDTH-1:0] mag;
        logic [3:0]            digit_buf [NUM_DIGITS];
        int                    n_digits;
        t_text_beat            beat;
        mag = value;
        // two's complement magnitude, exact for the most negative value
        if (value[DATA_WIDTH-1]) begin
            mag = ~mag + 1'b1;
        end
        n_digits = 0;
        do begin
            digit_buf[n_digits] = 4'(mag % RADIX);
            mag = mag / RADIX;
            n_digits++;
        end while (mag != 0 && n_digits < NUM_DIGITS);
        if (value[DATA_WIDTH-1]) begin
            beat.text_char = CHAR_MINUS;
            beat.last_char = 1'b0;
            text_owed.push_back(beat);
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            beat.text_char = CHAR_ZERO + 8'(digit_buf[i]);
            beat.last_char = (i == 0);
            text_owed.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_beat owed;
        if (!i_rst_n) begin
            text_owed.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_value_ch.valid && i_value_ch.ready) begin
                owe_text_of(i_value_ch.value);
            end
            if (i_text_ch.valid && i_text_ch.ready) begin
                if (text_owed.size() == 0) begin
                    $display("%0t: unexpected character transfer: expected none, got %0d last %0b",
                             $time, i_text_ch.text_char, i_text_ch.last_char);
                    o_fail_count++;
                end else begin
                    owed = text_owed.pop_front();
                    if (i_text_ch.text_char !== owed.text_char) begin
                        $display("%0t: text_char mismatch: expected %0d, got %0d",
                                 $time, owed.text_char, i_text_ch.text_char);
                        o_fail_count++;
                    end
                    if (i_text_ch.last_char !== owed.last_char) begin
                        $display("%0t: last_char mismatch: expected %0b, got %0b",
                                 $time, owed.last_char, i_text_ch.last_char);
                        o_fail_count++;
                    end
                end
            end
            o_pending = text_owed.size();
        end
    end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
// ---------------------------------------------------------------------------
// testbench
// Drives signed values into the integer to decimal text converter with
// random gaps and output stalls: a directed set of edge values first, then
// random values of every magnitude. The checker beside the block judges the
// characters; this module gives the verdict.
// ---------------------------------------------------------------------------
module testbench
    import itd_pkg::*;
();

    localparam int N_BLOCKS    = 5;
    localparam int BLOCK_ITEMS = 20;
    localparam int TAIL_CYCLES = 60;

    localparam logic signed [DATA_WIDTH-1:0] MAX_VALUE = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_VALUE = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic clk = 1'b0;
    logic rst_n;
    logic busy_phase;
    int   fail_count;
    int   pending;

    itd_in_if  value_ch ();
    itd_out_if text_ch ();

    integer_to_decimal_text DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_value_ch (value_ch),
        .o_text_ch  (text_ch)
    );

    itd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_value_ch   (value_ch),
        .i_text_ch    (text_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    // values of every size: full width, small, around powers of ten, shifted
    function automatic logic signed [DATA_WIDTH-1:0] random_value();
        logic [63:0]           raw;
        logic [DATA_WIDTH-1:0] v;
        longint unsigned       pow10;
        int                    kind;
        raw  = {$urandom, $urandom};
        kind = $urandom_range(0, 3);
        case (kind)
            0: v = raw[DATA_WIDTH-1:0];
            1: v = DATA_WIDTH'($urandom_range(0, 999));
            2: begin
                pow10 = 1;
                repeat ($urandom_range(1, NUM_DIGITS - 1)) pow10 *= 10;
                v = DATA_WIDTH'(pow10 - $urandom_range(0, 1));
            end
            default: v = raw[DATA_WIDTH-1:0] >> $urandom_range(0, DATA_WIDTH - 1);
        endcase
        if (kind != 0 && $urandom_range(0, 1)) begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_value(logic signed [DATA_WIDTH-1:0] v);
        int gap;
        gap = busy_phase ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            value_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        value_ch.value = v;
        value_ch.valid = 1'b1;
        do @(posedge clk); while (!value_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        value_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // output side: random stall before each character transfer
    initial begin
        int stall;
        text_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = busy_phase ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                text_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            text_ch.ready = 1'b1;
            do @(posedge clk); while (!text_ch.valid);
            @(negedge clk);
        end
    end

    initial begin
        logic signed [DATA_WIDTH-1:0] edge_values[$];
        rst_n          = 1'b0;
        busy_phase     = 1'b1;
        value_ch.valid = 1'b0;
        value_ch.value = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        edge_values = {0, 1, -1, 7, -5, 9, -9, 10, -10, 99, 100, 101,
                       999999999, 1000000000, -1000000000, 1234567890,
                       -1234567890, 2000000000, MAX_VALUE, MIN_VALUE,
                       MIN_VALUE + 1, 32'sh5555_5555, 32'shAAAA_AAAA};
        foreach (edge_values[i]) send_value(edge_values[i]);
        wait_drained();

        for (int b = 0; b < N_BLOCKS; b++) begin
            // some stretches run with no idling on either side
            busy_phase = (b % 2 == 0) || $urandom_range(0, 1);
            for (int i = 0; i < BLOCK_ITEMS; i++) begin
                send_value(random_value());
                if ($urandom_range(0, 9) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/itd_pkg.sv
rtl/itd_if.sv
rtl/integer_to_decimal_text.sv
tb/itd_checker.sv
tb/testbench.sv
